// ===== src/zsr_pkg.sv =====
// Shared types, codes and saturating arithmetic helpers for the Zolotarev sign evaluator.
// No dependencies.
`timescale 1ns / 1ps

package zsr_pkg;

    localparam int MAX_POLES = 32;
    localparam int FRAC_BITS = 32;
    localparam int WORD_W    = 64;
    localparam int POLE_W    = $clog2(MAX_POLES);
    localparam int SHIFT_W   = POLE_W + 1;
    localparam int DIVN_W    = WORD_W + FRAC_BITS;

    localparam logic [1:0] CMD_LOAD_NUM   = 2'd0;
    localparam logic [1:0] CMD_LOAD_SHIFT = 2'd1;
    localparam logic [1:0] CMD_EVAL       = 2'd2;
    localparam logic [1:0] CMD_NONE       = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SAT  = 2'd1;
    localparam logic [1:0] STAT_ZERO = 2'd2;

    localparam logic [2:0] ADDR_POLE_COUNT = 3'd0;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              sat;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQ_WAIT,
        ST_RD,
        ST_ADD,
        ST_DIV,
        ST_DIV_WAIT,
        ST_NEXT,
        ST_E_RD,
        ST_E_ADD,
        ST_M1,
        ST_M1_WAIT,
        ST_M2,
        ST_M2_WAIT,
        ST_OUT
    } state_t;

    function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
        magnitude = v[WORD_W-1] ? (WORD_W'(0) - v) : v;
    endfunction

    // Apply sign to a wide magnitude, saturating to the signed word range.
    function automatic res_t pack(input logic neg, input logic [2*WORD_W-1:0] m);
        logic [WORD_W-1:0] lim;
        res_t r;
        lim = neg ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        if (m[2*WORD_W-1:WORD_W] != '0 || m[WORD_W-1:0] > lim) begin
            r.sat   = 1'b1;
            r.value = lim;
        end else begin
            r.sat   = 1'b0;
            r.value = neg ? (WORD_W'(0) - m[WORD_W-1:0]) : m[WORD_W-1:0];
        end
        pack = r;
    endfunction

    function automatic res_t add_sat(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] s;
        res_t r;
        s = a + b;
        if (a[WORD_W-1] == b[WORD_W-1] && s[WORD_W-1] != a[WORD_W-1]) begin
            r.sat   = 1'b1;
            r.value = a[WORD_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            r.sat   = 1'b0;
            r.value = s;
        end
        add_sat = r;
    endfunction

endpackage

// ===== src/zsr_mul.sv =====
// Fixed-point signed multiplier: four 32x32 partial products, accumulated one at a time.
// Depends on zsr_pkg.
`timescale 1ns / 1ps

module zsr_mul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [zsr_pkg::WORD_W-1:0]  op_a,
    input  logic [zsr_pkg::WORD_W-1:0]  op_b,
    output logic                        done,
    output zsr_pkg::res_t               result
);

    localparam int HALF_W = zsr_pkg::WORD_W / 2;
    localparam int ACC_W  = 2 * zsr_pkg::WORD_W;

    logic [zsr_pkg::WORD_W-1:0] ma_reg, mb_reg;
    logic                       neg_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [1:0]                 cnt_reg;
    logic                       busy_reg, fin_reg, done_reg;
    zsr_pkg::res_t              result_reg;

    logic [HALF_W-1:0]          pa, pb;
    logic [2*HALF_W-1:0]        prod;
    logic [ACC_W-1:0]           pp;
    logic [ACC_W-1:0]           shifted;

    assign pa      = cnt_reg[0] ? ma_reg[zsr_pkg::WORD_W-1:HALF_W] : ma_reg[HALF_W-1:0];
    assign pb      = cnt_reg[1] ? mb_reg[zsr_pkg::WORD_W-1:HALF_W] : mb_reg[HALF_W-1:0];
    assign prod    = pa * pb;
    assign pp      = ACC_W'(prod) << (HALF_W * (int'(cnt_reg[0]) + int'(cnt_reg[1])));
    assign shifted = acc_reg >> zsr_pkg::FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            if (fin_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ma_reg  <= zsr_pkg::magnitude(op_a);
            mb_reg  <= zsr_pkg::magnitude(op_b);
            neg_reg <= op_a[zsr_pkg::WORD_W-1] ^ op_b[zsr_pkg::WORD_W-1];
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_reg + pp;
        end
        if (fin_reg) begin
            result_reg <= zsr_pkg::pack(neg_reg, shifted);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/zsr_div.sv =====
// Radix-2 restoring divider for (n << FRAC_BITS) / d, one quotient bit per cycle.
// Depends on zsr_pkg.
`timescale 1ns / 1ps

module zsr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [zsr_pkg::WORD_W-1:0]  numer,
    input  logic [zsr_pkg::WORD_W-1:0]  denom,
    output logic                        done,
    output zsr_pkg::res_t               result
);

    localparam int NW    = zsr_pkg::DIVN_W;
    localparam int W     = zsr_pkg::WORD_W;
    localparam int CNT_W = $clog2(NW);

    logic [NW-1:0]    num_reg, q_reg;
    logic [W-1:0]     rem_reg, dm_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, fin_reg, done_reg;
    zsr_pkg::res_t    result_reg;

    logic [W-1:0]     rem_sh;
    logic             take;

    assign rem_sh = {rem_reg[W-2:0], num_reg[NW-1]};
    assign take   = rem_reg[W-1] || (rem_sh >= dm_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            fin_reg  <= 1'b0;
            done_reg <= fin_reg;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= {zsr_pkg::magnitude(numer), {zsr_pkg::FRAC_BITS{1'b0}}};
            dm_reg  <= zsr_pkg::magnitude(denom);
            neg_reg <= numer[W-1] ^ denom[W-1];
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= take ? (rem_sh - dm_reg) : rem_sh;
            q_reg   <= {q_reg[NW-2:0], take};
        end
        if (fin_reg) begin
            result_reg <= zsr_pkg::pack(neg_reg, (2*W)'(q_reg));
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/zolotarev_sign_rational_eval.sv =====
// Top level of the Zolotarev rational sign evaluator: sequencer, coefficient memories, APB port.
// Depends on zsr_pkg, zsr_mul, zsr_div.
//
//   channel | direction | ports
//   s_      | in        | s_valid s_ready s_command s_table_index s_operand_value
//   m_      | out       | m_valid m_ready m_sign_value m_eval_status
//   apb     | in/out    | psel penable pwrite paddr pwdata prdata pready
//
// An evaluate passes each of its N poles, N the pole count, through the shared radix-2
// divider (96 quotient bits); a pole with a zero denominator skips the divider.
// s_ready is high only while the sequencer is idle; the result holds until taken.
// Reset is synchronous active-low; coefficient memories are not cleared.
`timescale 1ns / 1ps

module zolotarev_sign_rational_eval (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [5:0]  s_table_index,
    input  logic signed [63:0] s_operand_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [63:0] m_sign_value,
    output logic [1:0]  m_eval_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int W = zsr_pkg::WORD_W;
    localparam int PW = zsr_pkg::POLE_W;
    localparam int SW = zsr_pkg::SHIFT_W;

    logic [W-1:0] num_mem [zsr_pkg::MAX_POLES];
    logic [W-1:0] shift_mem [2*zsr_pkg::MAX_POLES];

    zsr_pkg::state_t state_reg, state_next;

    logic [5:0]   pole_count_reg;
    logic [W-1:0] x_reg, q_reg, sum_reg, d_reg, e_reg, r_reg;
    logic [W-1:0] b_rd_reg, c_rd_reg;
    logic [PW-1:0] l_reg, nm1_reg;
    logic         sat_reg, zero_reg;
    logic [W-1:0] out_val_reg;
    logic [1:0]   out_stat_reg;

    logic         in_acc, wr_cfg;
    logic         rd_en, rd_e;
    logic [SW-1:0] c_addr;
    logic         mul_start, div_start, mul_done, div_done;
    logic [W-1:0] mul_a, mul_b;
    zsr_pkg::res_t mul_res, div_res, add_d, add_e, add_s;
    logic [5:0]   n_clamp;

    assign in_acc = s_valid && s_ready;
    assign wr_cfg = psel && penable && pwrite && pready && (paddr == zsr_pkg::ADDR_POLE_COUNT);
    assign pready = 1'b1;
    assign prdata = (paddr == zsr_pkg::ADDR_POLE_COUNT) ? {26'd0, pole_count_reg} : 32'd0;

    assign n_clamp = (pole_count_reg == 6'd0) ? 6'd1 :
                     (pole_count_reg > 6'(zsr_pkg::MAX_POLES)) ? 6'(zsr_pkg::MAX_POLES) :
                     pole_count_reg;

    assign add_d = zsr_pkg::add_sat(q_reg, c_rd_reg);
    assign add_e = zsr_pkg::add_sat(q_reg, c_rd_reg);
    assign add_s = zsr_pkg::add_sat(sum_reg, div_res.value);

    zsr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    zsr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (b_rd_reg),
        .denom   (d_reg),
        .done    (div_done),
        .result  (div_res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            zsr_pkg::ST_IDLE:
                if (in_acc && s_command == zsr_pkg::CMD_EVAL) state_next = zsr_pkg::ST_SQ;
            zsr_pkg::ST_SQ:      state_next = zsr_pkg::ST_SQ_WAIT;
            zsr_pkg::ST_SQ_WAIT: if (mul_done) state_next = zsr_pkg::ST_RD;
            zsr_pkg::ST_RD:      state_next = zsr_pkg::ST_ADD;
            zsr_pkg::ST_ADD:
                state_next = (add_d.value == '0) ? zsr_pkg::ST_NEXT : zsr_pkg::ST_DIV;
            zsr_pkg::ST_DIV:      state_next = zsr_pkg::ST_DIV_WAIT;
            zsr_pkg::ST_DIV_WAIT: if (div_done) state_next = zsr_pkg::ST_NEXT;
            zsr_pkg::ST_NEXT:
                state_next = (l_reg == nm1_reg) ? zsr_pkg::ST_E_RD : zsr_pkg::ST_RD;
            zsr_pkg::ST_E_RD:    state_next = zsr_pkg::ST_E_ADD;
            zsr_pkg::ST_E_ADD:   state_next = zsr_pkg::ST_M1;
            zsr_pkg::ST_M1:      state_next = zsr_pkg::ST_M1_WAIT;
            zsr_pkg::ST_M1_WAIT: if (mul_done) state_next = zsr_pkg::ST_M2;
            zsr_pkg::ST_M2:      state_next = zsr_pkg::ST_M2_WAIT;
            zsr_pkg::ST_M2_WAIT: if (mul_done) state_next = zsr_pkg::ST_OUT;
            zsr_pkg::ST_OUT:     if (m_ready) state_next = zsr_pkg::ST_IDLE;
            default:             state_next = zsr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        rd_en     = 1'b0;
        rd_e      = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a     = x_reg;
        mul_b     = x_reg;
        unique case (state_reg)
            zsr_pkg::ST_IDLE: s_ready = 1'b1;
            zsr_pkg::ST_SQ:   mul_start = 1'b1;
            zsr_pkg::ST_RD:   rd_en = 1'b1;
            zsr_pkg::ST_DIV:  div_start = 1'b1;
            zsr_pkg::ST_E_RD: begin
                rd_en = 1'b1;
                rd_e  = 1'b1;
            end
            zsr_pkg::ST_M1: begin
                mul_start = 1'b1;
                mul_b     = sum_reg;
            end
            zsr_pkg::ST_M2: begin
                mul_start = 1'b1;
                mul_a     = r_reg;
                mul_b     = e_reg;
            end
            default: ;
        endcase
    end

    assign c_addr  = rd_e ? {nm1_reg, 1'b1} : {l_reg, 1'b0};
    assign m_valid = (state_reg == zsr_pkg::ST_OUT);
    assign m_sign_value  = out_val_reg;
    assign m_eval_status = out_stat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= zsr_pkg::ST_IDLE;
            pole_count_reg <= 6'd1;
        end else begin
            state_reg <= state_next;
            if (wr_cfg) pole_count_reg <= pwdata[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && s_command == zsr_pkg::CMD_LOAD_NUM && !s_table_index[5]) begin
            num_mem[s_table_index[PW-1:0]] <= s_operand_value;
        end
        if (in_acc && s_command == zsr_pkg::CMD_LOAD_SHIFT) begin
            shift_mem[s_table_index] <= s_operand_value;
        end
        if (rd_en) begin
            b_rd_reg <= num_mem[l_reg];
            c_rd_reg <= shift_mem[c_addr];
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            zsr_pkg::ST_IDLE: begin
                x_reg    <= s_operand_value;
                nm1_reg  <= PW'(n_clamp - 6'd1);
                l_reg    <= '0;
                sum_reg  <= '0;
                sat_reg  <= 1'b0;
                zero_reg <= 1'b0;
            end
            zsr_pkg::ST_SQ_WAIT: if (mul_done) begin
                q_reg   <= mul_res.value;
                sat_reg <= sat_reg | mul_res.sat;
            end
            zsr_pkg::ST_ADD: begin
                d_reg   <= add_d.value;
                sat_reg <= sat_reg | add_d.sat;
                if (add_d.value == '0) zero_reg <= 1'b1;
            end
            zsr_pkg::ST_DIV_WAIT: if (div_done) begin
                sum_reg <= add_s.value;
                sat_reg <= sat_reg | div_res.sat | add_s.sat;
            end
            zsr_pkg::ST_NEXT: l_reg <= l_reg + 1'b1;
            zsr_pkg::ST_E_ADD: begin
                e_reg   <= add_e.value;
                sat_reg <= sat_reg | add_e.sat;
            end
            zsr_pkg::ST_M1_WAIT: if (mul_done) begin
                r_reg   <= mul_res.value;
                sat_reg <= sat_reg | mul_res.sat;
            end
            zsr_pkg::ST_M2_WAIT: if (mul_done) begin
                out_val_reg  <= mul_res.value;
                out_stat_reg <= zero_reg ? zsr_pkg::STAT_ZERO :
                                (sat_reg | mul_res.sat) ? zsr_pkg::STAT_SAT : zsr_pkg::STAT_OK;
            end
            default: ;
        endcase
    end

    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("input ready while result pending");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sign_value) && $stable(m_eval_status))
        else $error("result changed before taken");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_eval_status == zsr_pkg::STAT_OK || m_eval_status == zsr_pkg::STAT_SAT ||
                     m_eval_status == zsr_pkg::STAT_ZERO)) else $error("bad status");

    a_units: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_start && div_start)) else $error("both units started");

endmodule
